// ----- sv/csc_pkg.sv -----
// ---------------------------------------------------------------------------
// csc_pkg: shared definitions for the column span clip and DDA setup unit
// Table geometry, divider geometry, function and register codes, stage types.
// ---------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

	localparam int TABLE_COLUMNS = 1024;
	localparam int TABLE_AW      = $clog2(TABLE_COLUMNS);
	localparam int TABLE_DW      = 32;

	// Restoring divider: one quotient bit per stage over the whole numerator.
	localparam int DIV_NW    = 64;
	localparam int DIV_DW    = 32;
	localparam int DIV_STEPS = DIV_NW;

	localparam int ADDR_W = 5;

	localparam logic [1:0] FUNC_INT   = 2'd0;
	localparam logic [1:0] FUNC_FIX   = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;

	localparam logic [2:0] REG_MIN_X     = 3'd0;
	localparam logic [2:0] REG_MAX_X     = 3'd1;
	localparam logic [2:0] REG_MIN_Y     = 3'd2;
	localparam logic [2:0] REG_MAX_Y     = 3'd3;
	localparam logic [2:0] REG_USE_TABLE = 3'd4;

	localparam logic [31:0] STEP_ONE = 32'h0001_0000;
	localparam logic [31:0] MIN_STEP = 32'd4;
	localparam logic [DIV_NW-1:0] INV_NUM = 64'h0000_0001_0000_0000;

	// Side data that rides along the step and start dividers.
	typedef struct packed {
		logic        fix;
		logic        rej;
		logic        force_step;
		logic        neg_step;
		logic        neg_part;
		logic [15:0] frac;
		logic [31:0] skip;
		logic [15:0] skip_sat;
		logic [15:0] rows_sat;
	} side_t;

	// Finished result that rides along the inverse divider.
	typedef struct packed {
		logic        rej;
		logic [15:0] skip_sat;
		logic [15:0] rows_sat;
		logic [31:0] start;
		logic [31:0] step;
	} fin_t;

	function automatic logic [15:0] sat16(input logic signed [34:0] v);
		logic [15:0] r;
		if (v < 35'sd0) begin
			r = 16'd0;
		end else if (v > 35'sd65535) begin
			r = 16'hFFFF;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/csc_ram.sv -----
// ---------------------------------------------------------------------------
// csc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- sv/csc_div.sv -----
// ---------------------------------------------------------------------------
// csc_div: pipelined unsigned restoring divider
// One quotient bit per stage; returns the low word of the quotient.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_div (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [csc_pkg::DIV_NW-1:0]  num,
	input  wire logic [csc_pkg::DIV_DW-1:0]  den,
	output logic      [csc_pkg::DIV_DW-1:0]  quo
);

	logic [csc_pkg::DIV_DW-1:0] rem_s [csc_pkg::DIV_STEPS];
	logic [csc_pkg::DIV_NW-1:0] nq_s  [csc_pkg::DIV_STEPS];
	logic [csc_pkg::DIV_DW-1:0] den_s [csc_pkg::DIV_STEPS];

	logic [csc_pkg::DIV_DW-1:0] rem_n [csc_pkg::DIV_STEPS];
	logic [csc_pkg::DIV_NW-1:0] nq_n  [csc_pkg::DIV_STEPS];
	logic [csc_pkg::DIV_DW-1:0] den_n [csc_pkg::DIV_STEPS];

	// The numerator shifts out of the top of nq while quotient bits shift in.
	always_comb begin
		logic [csc_pkg::DIV_DW-1:0] rp;
		logic [csc_pkg::DIV_DW-1:0] dp;
		logic [csc_pkg::DIV_NW-1:0] np;
		logic [csc_pkg::DIV_DW:0]   trial;
		logic                       fit;
		for (int k = 0; k < csc_pkg::DIV_STEPS; k++) begin
			if (k == 0) begin
				rp = '0;
				np = num;
				dp = den;
			end else begin
				rp = rem_s[k-1];
				np = nq_s[k-1];
				dp = den_s[k-1];
			end
			trial = {rp, np[csc_pkg::DIV_NW-1]};
			fit   = (trial >= {1'b0, dp});
			rem_n[k] = fit ? csc_pkg::DIV_DW'(trial - {1'b0, dp}) : trial[csc_pkg::DIV_DW-1:0];
			nq_n[k]  = {np[csc_pkg::DIV_NW-2:0], fit};
			den_n[k] = dp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < csc_pkg::DIV_STEPS; k++) begin
				rem_s[k] <= rem_n[k];
				nq_s[k]  <= nq_n[k];
				den_s[k] <= den_n[k];
			end
		end
	end

	assign quo = nq_s[csc_pkg::DIV_STEPS-1][csc_pkg::DIV_DW-1:0];

endmodule

`default_nettype wire

// ----- sv/column_span_clip_dda_setup_unit.sv -----
// ---------------------------------------------------------------------------
// column_span_clip_dda_setup_unit: textured column clip and DDA setup
// Clips one vertical span per beat and returns skip, rows, step, start and
// the inverse step; a third function writes the per-column limit table.
// ---------------------------------------------------------------------------
// Usage: an input beat carries func, column, top_y, screen_height,
// texture_height and the two table limits. Every input beat yields exactly
// one output beat, in order. Unless stalled, a new beat is taken every cycle;
// the rate is one item per cycle, set by the fully pipelined step, start and
// inverse dividers (64 stages each, one quotient bit per stage). The limit
// table is a 1024-entry RAM written at the accept edge of a table write and
// read at the accept edge of a span beat, so a span sees every table write
// that was accepted before it. The user must write the clip registers through
// the APB port only while the unit is idle; the unit does not enforce this.
// Reset clears the clip registers and all valid flags; table entries stay
// undefined until written. When out_stall is high with a result waiting, the
// whole pipeline holds and in_stall rises in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module column_span_clip_dda_setup_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,

	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [csc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,

	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 func,
	input  wire logic signed [15:0]         column,
	input  wire logic signed [31:0]         top_y,
	input  wire logic signed [31:0]         screen_height,
	input  wire logic signed [31:0]         texture_height,
	input  wire logic signed [15:0]         limit_top,
	input  wire logic signed [15:0]         limit_bottom,

	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            draw,
	output logic [15:0]                     skip_rows,
	output logic [15:0]                     draw_rows,
	output logic [31:0]                     dda_start,
	output logic [31:0]                     dda_step,
	output logic [31:0]                     dda_step_inverse
);

	localparam int LAST = csc_pkg::DIV_STEPS - 1;

	// ---------------- configuration ----------------
	logic signed [15:0] cfg_min_x_q, cfg_max_x_q, cfg_min_y_q, cfg_max_y_q;
	logic               cfg_use_q;
	logic [2:0]         reg_idx;
	logic               cfg_wr;

	assign reg_idx = paddr[csc_pkg::ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_min_x_q <= '0;
			cfg_max_x_q <= '0;
			cfg_min_y_q <= '0;
			cfg_max_y_q <= '0;
			cfg_use_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				csc_pkg::REG_MIN_X:     cfg_min_x_q <= pwdata[15:0];
				csc_pkg::REG_MAX_X:     cfg_max_x_q <= pwdata[15:0];
				csc_pkg::REG_MIN_Y:     cfg_min_y_q <= pwdata[15:0];
				csc_pkg::REG_MAX_Y:     cfg_max_y_q <= pwdata[15:0];
				csc_pkg::REG_USE_TABLE: cfg_use_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			csc_pkg::REG_MIN_X:     prdata = {16'd0, cfg_min_x_q};
			csc_pkg::REG_MAX_X:     prdata = {16'd0, cfg_max_x_q};
			csc_pkg::REG_MIN_Y:     prdata = {16'd0, cfg_min_y_q};
			csc_pkg::REG_MAX_Y:     prdata = {16'd0, cfg_max_y_q};
			csc_pkg::REG_USE_TABLE: prdata = {31'd0, cfg_use_q};
			default:                prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	logic adv, acc;
	logic out_valid_q;

	assign adv      = !(out_valid_q && out_stall);
	assign acc      = in_valid && adv;
	assign in_stall = !adv;

	// ---------------- accept: table access ----------------
	logic signed [16:0]              tab_off;
	logic                            tab_hit;
	logic                            tab_we;
	logic [csc_pkg::TABLE_DW-1:0]    tab_rdata;
	logic signed [32:0]              ysum;

	assign tab_off = 17'(column) - 17'(cfg_min_x_q);
	assign tab_hit = !tab_off[16] && (tab_off[15:0] < 16'(csc_pkg::TABLE_COLUMNS));
	assign tab_we  = acc && (func == csc_pkg::FUNC_WRITE)
		&& ($unsigned(column) < 16'(csc_pkg::TABLE_COLUMNS));
	assign ysum    = 33'(top_y) + 33'(screen_height);

	csc_ram #(
		.WIDTH(csc_pkg::TABLE_DW),
		.DEPTH(csc_pkg::TABLE_COLUMNS)
	) u_limits (
		.clk   (clk),
		.we    (tab_we),
		.waddr (column[csc_pkg::TABLE_AW-1:0]),
		.wdata ({limit_bottom, limit_top}),
		.re    (adv),
		.raddr (tab_off[csc_pkg::TABLE_AW-1:0]),
		.rdata (tab_rdata)
	);

	// ---------------- stage registers ----------------
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic [1:0]           func_s1;
	logic signed [15:0]   x_s1;
	logic signed [31:0]   y_s1, hscr_s1, hdata_s1;
	logic signed [32:0]   ysum_s1;
	logic                 tab_s1;

	logic                 fix_s2, rej_s2;
	logic signed [33:0]   y0_s2, e_s2, hh_s2;
	logic signed [15:0]   lo_s2, hi_s2;
	logic signed [34:0]   sraw_s2;
	logic signed [31:0]   hdata_s2, hscr_s2;
	logic [15:0]          frac_s2;

	logic                 fix_s3, rej_s3;
	logic signed [34:0]   skip_s3, rows_s3;
	logic signed [31:0]   hdata_s3, hscr_s3;
	logic [15:0]          frac_s3;

	logic                 fix_s4, rej_s4, c1_s4, sg1_s4, skpos_s4;
	logic signed [48:0]   prod_s4;
	logic [csc_pkg::DIV_NW-1:0] num1_s4;
	logic [15:0]          skip_sat_s4, rows_sat_s4, frac_s4;
	logic [31:0]          skip32_s4;
	logic signed [31:0]   hscr_s4;

	// ---------------- stage 2: limits and row bounds ----------------
	logic               span_ok, use_tab, rej2, fix2;
	logic signed [15:0] lo2, hi2, y_hi;
	logic signed [16:0] e_hi;
	logic signed [33:0] y0_2, e_2, hh_2;

	always_comb begin
		span_ok = (func_s1 == csc_pkg::FUNC_INT) || (func_s1 == csc_pkg::FUNC_FIX);
		fix2    = (func_s1 == csc_pkg::FUNC_FIX);
		rej2    = !span_ok || (hscr_s1 <= 32'sd0) || (x_s1 < cfg_min_x_q)
			|| (x_s1 >= cfg_max_x_q);
		use_tab = cfg_use_q && tab_s1;
		lo2     = use_tab ? $signed(tab_rdata[15:0])  : cfg_min_y_q;
		hi2     = use_tab ? $signed(tab_rdata[31:16]) : cfg_max_y_q;
		y_hi    = $signed(y_s1[31:16]);
		e_hi    = $signed(ysum_s1[32:16]);
		y0_2    = fix2 ? 34'(y_hi) : 34'(y_s1);
		e_2     = fix2 ? 34'(e_hi) : 34'(ysum_s1);
		hh_2    = fix2 ? (e_2 - y0_2) : 34'(hscr_s1);
	end

	// ---------------- stage 3: row clipping ----------------
	logic               sneg, r1, r2, r3;
	logic signed [34:0] s3_skip, s3_rows;
	logic signed [33:0] ys;

	always_comb begin
		sneg    = (sraw_s2 < 35'sd0);
		s3_skip = sneg ? 35'sd0 : sraw_s2;
		r1      = !sneg && (sraw_s2 >= 35'(hh_s2));
		r2      = (e_s2 <= 34'(lo_s2));
		ys      = sneg ? y0_s2 : 34'(lo_s2);
		r3      = (ys >= 34'(hi_s2));
		s3_rows = (e_s2 >= 34'(hi_s2)) ? (35'(hi_s2) - 35'(ys)) : (35'(hh_s2) - s3_skip);
	end

	// ---------------- stage 4: product and step numerator ----------------
	logic signed [48:0] prod4;
	logic [31:0]        ahd;
	logic               c1_4;

	always_comb begin
		prod4 = 49'(hdata_s3) * 49'($signed({1'b0, skip_s3[15:0]}));
		ahd   = hdata_s3[31] ? 32'(-hdata_s3) : hdata_s3;
		c1_4  = (32'($signed(hdata_s3[31:16])) >= hscr_s3);
	end

	// ---------------- divider feed ----------------
	logic signed [48:0]         aprod;
	logic                       c2;
	logic [csc_pkg::DIV_NW-1:0] num2;
	csc_pkg::side_t             side_in;

	always_comb begin
		aprod = prod_s4[48] ? -prod_s4 : prod_s4;
		c2    = skpos_s4 && (33'(prod_s4 >>> 16) >= 33'(hscr_s4));
		num2  = {aprod[47:0], 16'd0};
		side_in.fix        = fix_s4;
		side_in.rej        = rej_s4;
		side_in.force_step = c1_s4 || c2;
		side_in.neg_step   = sg1_s4;
		side_in.neg_part   = prod_s4[48];
		side_in.frac       = frac_s4;
		side_in.skip       = skip32_s4;
		side_in.skip_sat   = skip_sat_s4;
		side_in.rows_sat   = rows_sat_s4;
	end

	logic [31:0] q_step, q_part, q_inv;

	csc_div u_div_step (
		.clk (clk),
		.en  (adv),
		.num (num1_s4),
		.den (hscr_s4),
		.quo (q_step)
	);

	csc_div u_div_part (
		.clk (clk),
		.en  (adv),
		.num (num2),
		.den (hscr_s4),
		.quo (q_part)
	);

	csc_pkg::side_t               side_s [csc_pkg::DIV_STEPS];
	logic [csc_pkg::DIV_STEPS-1:0] vdiv_s;

	// ---------------- post divider stages ----------------
	csc_pkg::side_t sd;
	logic [31:0]    step1, part1;
	logic           rej1;

	always_comb begin
		sd    = side_s[LAST];
		part1 = sd.neg_part ? 32'(-q_part) : q_part;
		if (!sd.fix) begin
			step1 = q_step;
		end else if (sd.force_step) begin
			step1 = csc_pkg::STEP_ONE;
		end else begin
			step1 = sd.neg_step ? 32'(-q_step) : q_step;
		end
		rej1 = sd.rej || (!sd.fix && (q_step < csc_pkg::MIN_STEP));
	end

	logic           v_t1, v_t2, v_t3;
	logic           rej_t1, fix_t1, force_t1;
	logic [31:0]    step_t1, part_t1, skip32_t1;
	logic [15:0]    frac_t1, skip_sat_t1, rows_sat_t1;

	logic           rej_t2, fix_t2, force_t2;
	logic [31:0]    step_t2, part_t2;
	logic [47:0]    mprod_t2;
	logic [15:0]    skip_sat_t2, rows_sat_t2;

	csc_pkg::fin_t  fin_t3;

	logic signed [32:0] ma, mb;
	logic signed [65:0] mprod;
	logic [31:0]        start3;

	always_comb begin
		ma    = fix_t1 ? $signed({17'd0, frac_t1}) : $signed({1'b0, skip32_t1});
		mb    = fix_t1 ? $signed({step_t1[31], step_t1}) : $signed({1'b0, step_t1});
		mprod = 66'(ma) * 66'(mb);
		if (!fix_t2) begin
			start3 = (step_t2 >> 1) + mprod_t2[31:0];
		end else if (force_t2) begin
			start3 = '0;
		end else begin
			start3 = mprod_t2[47:16] + part_t2;
		end
	end

	csc_div u_div_inv (
		.clk (clk),
		.en  (adv),
		.num (csc_pkg::INV_NUM),
		.den (fin_t3.step),
		.quo (q_inv)
	);

	csc_pkg::fin_t                 fin_s [csc_pkg::DIV_STEPS];
	logic [csc_pkg::DIV_STEPS-1:0] vinv_s;
	csc_pkg::fin_t                 ff;
	logic [31:0]                   inv_o;

	always_comb begin
		ff    = fin_s[LAST];
		inv_o = (ff.step <= 32'd1) ? '1 : q_inv;
	end

	// ---------------- valid flags ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			vdiv_s      <= '0;
			v_t1        <= 1'b0;
			v_t2        <= 1'b0;
			v_t3        <= 1'b0;
			vinv_s      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			vdiv_s      <= {vdiv_s[csc_pkg::DIV_STEPS-2:0], v_s4};
			v_t1        <= vdiv_s[LAST];
			v_t2        <= v_t1;
			v_t3        <= v_t2;
			vinv_s      <= {vinv_s[csc_pkg::DIV_STEPS-2:0], v_t3};
			out_valid_q <= vinv_s[LAST];
		end
	end

	// ---------------- payload ----------------
	logic        draw_q;
	logic [15:0] skip_rows_q, draw_rows_q;
	logic [31:0] dda_start_q, dda_step_q, dda_inv_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1  <= func;
			x_s1     <= column;
			y_s1     <= top_y;
			hscr_s1  <= screen_height;
			hdata_s1 <= texture_height;
			ysum_s1  <= ysum;
			tab_s1   <= tab_hit;

			fix_s2   <= fix2;
			rej_s2   <= rej2;
			y0_s2    <= y0_2;
			e_s2     <= e_2;
			hh_s2    <= hh_2;
			lo_s2    <= lo2;
			hi_s2    <= hi2;
			sraw_s2  <= 35'(lo2) - 35'(y0_2);
			hdata_s2 <= hdata_s1;
			hscr_s2  <= hscr_s1;
			frac_s2  <= ~y_s1[15:0];

			fix_s3   <= fix_s2;
			rej_s3   <= rej_s2 || r1 || r2 || r3;
			skip_s3  <= s3_skip;
			rows_s3  <= s3_rows;
			hdata_s3 <= hdata_s2;
			hscr_s3  <= hscr_s2;
			frac_s3  <= frac_s2;

			fix_s4      <= fix_s3;
			rej_s4      <= rej_s3;
			c1_s4       <= c1_4;
			sg1_s4      <= fix_s3 && hdata_s3[31];
			skpos_s4    <= (skip_s3 != 35'sd0);
			prod_s4     <= prod4;
			num1_s4     <= fix_s3 ? {16'd0, ahd, 16'd0} : {32'd0, hdata_s3[15:0], 16'd0};
			skip_sat_s4 <= csc_pkg::sat16(skip_s3);
			rows_sat_s4 <= csc_pkg::sat16(rows_s3);
			skip32_s4   <= skip_s3[31:0];
			frac_s4     <= frac_s3;
			hscr_s4     <= hscr_s3;

			side_s[0] <= side_in;
			for (int k = 1; k < csc_pkg::DIV_STEPS; k++) begin
				side_s[k] <= side_s[k-1];
			end

			rej_t1      <= rej1;
			fix_t1      <= sd.fix;
			force_t1    <= sd.force_step;
			step_t1     <= step1;
			part_t1     <= part1;
			skip32_t1   <= sd.skip;
			frac_t1     <= sd.frac;
			skip_sat_t1 <= sd.skip_sat;
			rows_sat_t1 <= sd.rows_sat;

			rej_t2      <= rej_t1;
			fix_t2      <= fix_t1;
			force_t2    <= force_t1;
			step_t2     <= step_t1;
			part_t2     <= part_t1;
			mprod_t2    <= mprod[47:0];
			skip_sat_t2 <= skip_sat_t1;
			rows_sat_t2 <= rows_sat_t1;

			fin_t3.rej      <= rej_t2;
			fin_t3.skip_sat <= skip_sat_t2;
			fin_t3.rows_sat <= rows_sat_t2;
			fin_t3.start    <= start3;
			fin_t3.step     <= step_t2;

			fin_s[0] <= fin_t3;
			for (int k = 1; k < csc_pkg::DIV_STEPS; k++) begin
				fin_s[k] <= fin_s[k-1];
			end

			draw_q      <= !ff.rej;
			skip_rows_q <= ff.rej ? 16'd0 : ff.skip_sat;
			draw_rows_q <= ff.rej ? 16'd0 : ff.rows_sat;
			dda_start_q <= ff.rej ? 32'd0 : ff.start;
			dda_step_q  <= ff.rej ? 32'd0 : ff.step;
			dda_inv_q   <= ff.rej ? 32'd0 : inv_o;
		end
	end

	assign out_valid        = out_valid_q;
	assign draw             = draw_q;
	assign skip_rows        = skip_rows_q;
	assign draw_rows        = draw_rows_q;
	assign dda_start        = dda_start_q;
	assign dda_step         = dda_step_q;
	assign dda_step_inverse = dda_inv_q;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Column span clip and DDA setup unit testbench
// Drives span, fixed-point span and table write beats with random gaps and
// output stalls, reprograms the clip registers between phases, predicts
// every result beat and compares it field by field in order.
// ---------------------------------------------------------------------------
module testbench;
	import csc_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_ITEMS = 135;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	typedef struct {
		logic [1:0]         func;
		logic signed [15:0] column;
		logic signed [31:0] top_y;
		logic signed [31:0] screen_height;
		logic signed [31:0] texture_height;
		logic signed [15:0] limit_top;
		logic signed [15:0] limit_bottom;
	} span_req_t;

	typedef struct {
		logic        draw;
		logic [15:0] skip_rows;
		logic [15:0] draw_rows;
		logic [31:0] dda_start;
		logic [31:0] dda_step;
		logic [31:0] dda_step_inverse;
	} span_res_t;

	class span_scoreboard;
		int clip_min_x, clip_max_x, clip_min_y, clip_max_y;
		bit use_table;
		bit [31:0] col_limits[TABLE_COLUMNS];
		span_res_t pending_spans[$];
		int errors;
		int n_in;

		function longint sat16(longint v);
			if (v < 0) return 0;
			return (v > 65535) ? 65535 : v;
		endfunction

		function span_res_t predict_span(span_req_t r);
			span_res_t o;
			longint x, y, hscr, hdata, lo, hi, y0, hh, s, rows, d, frac, sd, idx;
			bit [31:0] step, start;
			bit [63:0] q;
			o = '{default: '0};
			x = r.column;
			y = r.top_y;
			hscr = r.screen_height;
			hdata = r.texture_height;
			lo = clip_min_y;
			hi = clip_max_y;
			if (r.func == FUNC_WRITE) begin
				if (r.column[15:0] < TABLE_COLUMNS)
					col_limits[r.column[15:0]] = {r.limit_bottom, r.limit_top};
				return o;
			end
			if (r.func != FUNC_INT && r.func != FUNC_FIX) return o;
			if (hscr <= 0 || x < clip_min_x || x >= clip_max_x) return o;
			if (use_table) begin
				idx = x - clip_min_x;
				if (idx >= 0 && idx < TABLE_COLUMNS) begin
					lo = $signed(col_limits[idx][15:0]);
					hi = $signed(col_limits[idx][31:16]);
				end
			end
			if (r.func == FUNC_INT) begin
				y0 = y;
				hh = hscr;
			end else begin
				y0 = y >>> 16;
				hh = ((y + hscr) >>> 16) - y0;
			end
			s = lo - y0;
			if (s < 0) s = 0;
			else if (s >= hh) return o;
			if (y0 + hh <= lo || y0 + s >= hi) return o;
			rows = (y0 + hh >= hi) ? (hi - y0 - s) : (hh - s);
			if (r.func == FUNC_INT) begin
				step = {r.texture_height[15:0], 16'h0} / r.screen_height[31:0];
				if (step < MIN_STEP) return o;
				start = (step >> 1) + step * s[31:0];
			end else if ((hdata >>> 16) >= hscr || (s > 0 && ((hdata * s) >>> 16) >= hscr)) begin
				step = STEP_ONE;
				start = 0;
			end else begin
				d = (hdata * 65536) / hscr;
				frac = 64'hFFFF - (y & 64'hFFFF);
				step = d[31:0];
				sd = $signed(step);
				d = ((frac * sd) >>> 16) + (hdata * (s * 65536)) / hscr;
				start = d[31:0];
			end
			if (step == 0) begin
				o.dda_step_inverse = '1;
			end else begin
				q = 64'h1_0000_0000 / step;
				o.dda_step_inverse = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
			end
			o.draw = 1'b1;
			o.skip_rows = 16'(sat16(s));
			o.draw_rows = 16'(sat16(rows));
			o.dda_start = start;
			o.dda_step = step;
			return o;
		endfunction

		function void note_input(span_req_t r);
			n_in++;
			pending_spans.push_back(predict_span(r));
		endfunction

		function void check_result(span_res_t a);
			span_res_t e;
			if (pending_spans.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				errors++;
				return;
			end
			e = pending_spans.pop_front();
			if (a.draw !== e.draw) begin
				$display("%0t: draw exp %0d got %0d", $time, e.draw, a.draw);
				errors++;
			end
			if (a.skip_rows !== e.skip_rows) begin
				$display("%0t: skip_rows exp %0d got %0d", $time, e.skip_rows, a.skip_rows);
				errors++;
			end
			if (a.draw_rows !== e.draw_rows) begin
				$display("%0t: draw_rows exp %0d got %0d", $time, e.draw_rows, a.draw_rows);
				errors++;
			end
			if (a.dda_start !== e.dda_start) begin
				$display("%0t: dda_start exp %h got %h", $time, e.dda_start, a.dda_start);
				errors++;
			end
			if (a.dda_step !== e.dda_step) begin
				$display("%0t: dda_step exp %h got %h", $time, e.dda_step, a.dda_step);
				errors++;
			end
			if (a.dda_step_inverse !== e.dda_step_inverse) begin
				$display("%0t: dda_step_inverse exp %h got %h", $time,
					e.dda_step_inverse, a.dda_step_inverse);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = '0;
	logic signed [15:0] column = '0;
	logic signed [31:0] top_y = '0, screen_height = '0, texture_height = '0;
	logic signed [15:0] limit_top = '0, limit_bottom = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic draw;
	logic [15:0] skip_rows, draw_rows;
	logic [31:0] dda_start, dda_step, dda_step_inverse;

	span_scoreboard sb = new();
	bit tbl_written[TABLE_COLUMNS];
	bit calm;
	int idle_cycles;

	column_span_clip_dda_setup_unit u_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sb.note_input('{func, column, top_y, screen_height, texture_height,
				limit_top, limit_bottom});
		end
		if (out_valid && !out_stall) begin
			sb.check_result('{draw, skip_rows, draw_rows, dda_start, dda_step,
				dda_step_inverse});
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Receiver: random stalls, plus one long hold so the pipeline backs up.
	initial begin
		int burst;
		bit held;
		burst = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (!held && sb.n_in >= 300) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
					: $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MIN_X: sb.clip_min_x = $signed(v[15:0]);
			REG_MAX_X: sb.clip_max_x = $signed(v[15:0]);
			REG_MIN_Y: sb.clip_min_y = $signed(v[15:0]);
			REG_MAX_Y: sb.clip_max_y = $signed(v[15:0]);
			REG_USE_TABLE: sb.use_table = v[0];
			default: ;
		endcase
	endtask

	task automatic set_clip(int mnx, int mxx, int mny, int mxy, bit tbl);
		reg_write(REG_MIN_X, 32'(mnx));
		reg_write(REG_MAX_X, 32'(mxx));
		reg_write(REG_MIN_Y, 32'(mny));
		reg_write(REG_MAX_Y, 32'(mxy));
		reg_write(REG_USE_TABLE, 32'(tbl));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending_spans.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send(span_req_t r);
		int gap;
		in_valid <= 1'b1;
		func <= r.func;
		column <= r.column;
		top_y <= r.top_y;
		screen_height <= r.screen_height;
		texture_height <= r.texture_height;
		limit_top <= r.limit_top;
		limit_bottom <= r.limit_bottom;
		if (r.func == FUNC_WRITE && r.column[15:0] < TABLE_COLUMNS)
			tbl_written[r.column[15:0]] = 1;
		do @(posedge clk); while (in_stall);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic span_req_t mk(logic [1:0] f, int c, int y, int hs, int ht,
			int lt = 0, int lb = 0);
		return '{f, 16'(c), y, hs, ht, 16'(lt), 16'(lb)};
	endfunction

	function automatic span_req_t rand_req();
		span_req_t r;
		int k, width, yi, hi, ti;
		k = $urandom_range(0, 19);
		r.func = (k < 8) ? FUNC_INT : (k < 16) ? FUNC_FIX : (k < 19) ? FUNC_WRITE : FUNC_NONE;
		r.top_y = $urandom;
		r.screen_height = $urandom;
		r.texture_height = $urandom;
		r.limit_top = 16'($urandom);
		r.limit_bottom = 16'($urandom);
		if (r.func == FUNC_WRITE) begin
			r.column = ($urandom_range(0, 15) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, TABLE_COLUMNS - 1));
			if ($urandom_range(0, 7) != 0) begin
				r.limit_top = 16'(int'($urandom_range(0, 200)) - 50);
				r.limit_bottom = r.limit_top + 16'(int'($urandom_range(0, 250)) - 20);
			end
			return r;
		end
		width = sb.clip_max_x - sb.clip_min_x;
		if (width <= 0 || width > 2000) width = 2000;
		r.column = ($urandom_range(0, 9) == 0) ? 16'($urandom)
			: 16'(sb.clip_min_x + int'($urandom_range(0, width + 8)) - 4);
		yi = (sb.use_table ? 0 : sb.clip_min_y) + int'($urandom_range(0, 400)) - 150;
		hi = $urandom_range(1, 300);
		ti = $urandom_range(0, 600);
		k = $urandom_range(0, 19);
		if (k == 0) hi = -int'($urandom_range(0, 5));
		if (r.func == FUNC_INT) begin
			if ($urandom_range(0, 9) != 0) r.top_y = yi;
			if (k > 1) r.screen_height = hi;
			if ($urandom_range(0, 7) != 0) r.texture_height = ti;
		end else begin
			if ($urandom_range(0, 9) != 0) r.top_y = (yi <<< 16) | $urandom_range(0, 16'hFFFF);
			if (k > 1) r.screen_height = (k == 2) ? $urandom_range(0, 16'hFFFF)
				: (hi <<< 16) | $urandom_range(0, 16'hFFFF);
			if ($urandom_range(0, 7) != 0)
				r.texture_height = (ti <<< 16) | $urandom_range(0, 16'hFFFF);
		end
		return r;
	endfunction

	task automatic run_random(int n);
		span_req_t r;
		longint idx;
		repeat (n) begin
			r = rand_req();
			idx = longint'(r.column) - sb.clip_min_x;
			// Never let a span read a table entry that holds nothing yet.
			if (sb.use_table && (r.func == FUNC_INT || r.func == FUNC_FIX) &&
					idx >= 0 && idx < TABLE_COLUMNS && !tbl_written[idx]) begin
				send(mk(FUNC_WRITE, int'(idx), 0, 0, 0,
					int'($urandom_range(0, 100)) - 20, $urandom_range(60, 260)));
			end
			send(r);
		end
	endtask

	initial begin
		span_req_t dir[$];
		int mnx, mny;
		calm = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_clip(-32768, 32767, -32768, 32767, 0);
		run_random(PHASE_ITEMS);
		wait_drained();

		set_clip(0, 320, 0, 200, 0);
		dir = '{
			mk(FUNC_INT, 10, 20, 100, 64),
			mk(FUNC_INT, 0, -30, 100, 100),
			mk(FUNC_INT, 319, 150, 100, 200),
			mk(FUNC_INT, 5, -200, 50, 10),
			mk(FUNC_INT, 5, 10, 100, 0),
			mk(FUNC_INT, 5, 10, 0, 10),
			mk(FUNC_FIX, 5, 10, -5, 10),
			mk(FUNC_INT, 320, 10, 20, 20),
			mk(FUNC_INT, -1, 10, 20, 20),
			mk(FUNC_FIX, 7, (10 << 16) | 'h8000, (50 << 16) | 'h1234, 20 << 16),
			mk(FUNC_FIX, 7, 5 << 16, 10 << 16, 40 << 16),
			mk(FUNC_FIX, 8, -(20 << 16), 100 << 16, 60 << 16),
			mk(FUNC_FIX, 9, (10 << 16) | 'h100, 'h100, 5 << 16),
			mk(FUNC_NONE, 9, 1, 1, 1),
			mk(FUNC_WRITE, 1023, 0, 0, 0, -32768, 32767),
			mk(FUNC_WRITE, 1024, 0, 0, 0, 5, 6),
			mk(FUNC_WRITE, -1, 0, 0, 0, 7, 8),
			mk(FUNC_INT, 1, -100000, 300000, 5),
			mk(FUNC_INT, 2, 32'h7FFF_FFFF, 1, 1),
			mk(FUNC_FIX, 2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
			mk(FUNC_INT, 3, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF)
		};
		foreach (dir[i]) send(dir[i]);
		run_random(PHASE_ITEMS);
		wait_drained();

		calm = 1;
		set_clip(0, 320, 0, 200, 1);
		run_random(PHASE_ITEMS);
		wait_drained();
		calm = 0;

		mnx = int'($urandom_range(0, 4000)) - 2000;
		mny = int'($urandom_range(0, 400)) - 200;
		set_clip(mnx, mnx + int'($urandom_range(0, 1500)), mny,
			mny + int'($urandom_range(0, 400)), 1);
		run_random(PHASE_ITEMS);
		wait_drained();

		set_clip(100, 1200, -50, 60, 1);
		run_random(PHASE_ITEMS);
		wait_drained();

		set_clip(32767, -32768, 32767, -32768, 0);
		run_random(PHASE_ITEMS / 4);
		wait_drained();
		set_clip(-300, 700, -20, 120, 0);
		run_random(PHASE_ITEMS);
		wait_drained();

		repeat (200) @(posedge clk);
		if (sb.pending_spans.size() != 0)
			$display("%0t: %0d results never arrived", $time, sb.pending_spans.size());
		if (sb.errors == 0 && sb.pending_spans.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
